// ===== rtl/aat_pkg.sv =====
// Shared types and constants for the transformed bounding box pipeline.
// Holds the beat structs, fixed-point widths and register indexes.
// Depends on nothing.
package aat_pkg;

    localparam int COORD_W     = 32;
    localparam int COORD_BITS  = 32;
    localparam int COEFF_W     = 21;
    localparam int COEFF_FRAC  = 16;
    localparam int ROW_W       = 3 * COEFF_W;
    localparam int CFG_INDEX_W = 3;
    localparam int PROD_W      = COEFF_W + COORD_W;
    localparam int TERM_W      = PROD_W - COEFF_FRAC;
    localparam int SUM_W       = TERM_W + 2;

    localparam logic [CFG_INDEX_W-1:0] REG_ROW_X    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW_Y    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW_Z    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_X = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_Y = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_Z = 3'd5;

    localparam logic [ROW_W-1:0] ROW_X_RESET = ROW_W'(1) << COEFF_FRAC;
    localparam logic [ROW_W-1:0] ROW_Y_RESET = ROW_W'(1) << (COEFF_FRAC + COEFF_W);
    localparam logic [ROW_W-1:0] ROW_Z_RESET = ROW_W'(1) << (COEFF_FRAC + 2 * COEFF_W);

    localparam logic signed [PROD_W-1:0] ROUND_HALF =
        {{(PROD_W-COEFF_FRAC){1'b0}}, 1'b1, {(COEFF_FRAC-1){1'b0}}};
    localparam logic signed [SUM_W-1:0] SAT_HI =
        {{(SUM_W-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;

    typedef struct packed {
        logic signed [COORD_W-1:0] in_min_x;
        logic signed [COORD_W-1:0] in_min_y;
        logic signed [COORD_W-1:0] in_min_z;
        logic signed [COORD_W-1:0] in_max_x;
        logic signed [COORD_W-1:0] in_max_y;
        logic signed [COORD_W-1:0] in_max_z;
    } box_in_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] out_min_x;
        logic signed [COORD_W-1:0] out_min_y;
        logic signed [COORD_W-1:0] out_min_z;
        logic signed [COORD_W-1:0] out_max_x;
        logic signed [COORD_W-1:0] out_max_y;
        logic signed [COORD_W-1:0] out_max_z;
        logic                      clipped;
    } box_out_t;

    typedef struct packed {
        logic s1_en;
        logic s2_en;
        logic s3_en;
        logic s4_en;
    } stage_ctrl_t;

endpackage

// ===== rtl/aat_axis.sv =====
// Datapath of one output axis: multiply, round and pick, sum, clamp.
// Stage enables come from the top level; uses aat_pkg.
module aat_axis
    import aat_pkg::*;
(
    input  logic                      clk,
    input  stage_ctrl_t               ctrl,
    input  logic signed [COEFF_W-1:0] coeffs [3],
    input  logic signed [COORD_W-1:0] offset,
    input  logic signed [COORD_W-1:0] lo [3],
    input  logic signed [COORD_W-1:0] hi [3],
    output logic signed [COORD_W-1:0] axis_min,
    output logic signed [COORD_W-1:0] axis_max,
    output logic                      axis_clip
);

    logic signed [PROD_W-1:0] prod_lo_reg [3];
    logic signed [PROD_W-1:0] prod_hi_reg [3];
    logic signed [PROD_W-1:0] prod_lo_next [3];
    logic signed [PROD_W-1:0] prod_hi_next [3];
    logic signed [TERM_W-1:0] tmin_reg [3];
    logic signed [TERM_W-1:0] tmax_reg [3];
    logic signed [TERM_W-1:0] tmin_next [3];
    logic signed [TERM_W-1:0] tmax_next [3];
    logic signed [SUM_W-1:0]  smin_reg;
    logic signed [SUM_W-1:0]  smax_reg;
    logic signed [SUM_W-1:0]  smin_next;
    logic signed [SUM_W-1:0]  smax_next;
    logic signed [COORD_W-1:0] min_reg;
    logic signed [COORD_W-1:0] max_reg;
    logic                      clip_reg;
    logic signed [COORD_W-1:0] min_next;
    logic signed [COORD_W-1:0] max_next;
    logic                      clip_next;

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            prod_lo_next[j] = PROD_W'(coeffs[j]) * PROD_W'(lo[j]);
            prod_hi_next[j] = PROD_W'(coeffs[j]) * PROD_W'(hi[j]);
        end
    end

    // round half up, then keep the smaller and larger term of each column
    always_comb
    begin
        logic [PROD_W-1:0]        rnd_lo;
        logic [PROD_W-1:0]        rnd_hi;
        logic signed [TERM_W-1:0] t_lo;
        logic signed [TERM_W-1:0] t_hi;
        for (int j = 0; j < 3; j++)
        begin
            rnd_lo = prod_lo_reg[j] + ROUND_HALF;
            rnd_hi = prod_hi_reg[j] + ROUND_HALF;
            t_lo = rnd_lo[PROD_W-1:COEFF_FRAC];
            t_hi = rnd_hi[PROD_W-1:COEFF_FRAC];
            tmin_next[j] = (t_lo < t_hi) ? t_lo : t_hi;
            tmax_next[j] = (t_lo < t_hi) ? t_hi : t_lo;
        end
    end

    always_comb
    begin
        smin_next = SUM_W'(offset) + SUM_W'(tmin_reg[0]) + SUM_W'(tmin_reg[1])
                  + SUM_W'(tmin_reg[2]);
        smax_next = SUM_W'(offset) + SUM_W'(tmax_reg[0]) + SUM_W'(tmax_reg[1])
                  + SUM_W'(tmax_reg[2]);
    end

    always_comb
    begin
        if (smin_reg > SAT_HI)
            min_next = SAT_HI[COORD_W-1:0];
        else if (smin_reg < SAT_LO)
            min_next = SAT_LO[COORD_W-1:0];
        else
            min_next = smin_reg[COORD_W-1:0];
        if (smax_reg > SAT_HI)
            max_next = SAT_HI[COORD_W-1:0];
        else if (smax_reg < SAT_LO)
            max_next = SAT_LO[COORD_W-1:0];
        else
            max_next = smax_reg[COORD_W-1:0];
        clip_next = (smax_reg > SAT_HI) || (smin_reg < SAT_LO);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.s1_en)
        begin
            prod_lo_reg <= prod_lo_next;
            prod_hi_reg <= prod_hi_next;
        end
        if (ctrl.s2_en)
        begin
            tmin_reg <= tmin_next;
            tmax_reg <= tmax_next;
        end
        if (ctrl.s3_en)
        begin
            smin_reg <= smin_next;
            smax_reg <= smax_next;
        end
        if (ctrl.s4_en)
        begin
            min_reg  <= min_next;
            max_reg  <= max_next;
            clip_reg <= clip_next;
        end
    end

    assign axis_min  = min_reg;
    assign axis_max  = max_reg;
    assign axis_clip = clip_reg;

endmodule

// ===== rtl/affine_aabb_transform_top.sv =====
// Top level of the transformed bounding box block: config registers,
// stage valid chain and three axis datapaths. Uses aat_pkg and aat_axis.
//
// Usage:
//   in channel  (in_valid/in_ready/in_data): one box beat, min and max
//     corners in signed Q16.16.
//   out channel (out_valid/out_ready/out_data): the box around the eight
//     mapped corners, plus clipped when any corner coordinate saturated.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): rows 0..2 take
//     three Q5.16 coefficients, offsets 3..5 take the low 32 data bits;
//     other indexes are dropped. cfg_ready is always high. Write only while
//     the pipeline is empty.
// Throughput is one box per clock while out_ready is high. Four register
//   stages: multiply, round and pick, offset plus three-term sum, clamp.
//   Each stage is registered, and out_valid comes from the clamp stage.
// Reset empties the pipeline and loads the identity map.
// When out_ready is low, each full stage holds while every stage after it
//   is full; empty stages still fill, so in_ready drops only once all four
//   stages hold a beat.
module affine_aabb_transform_top
    import aat_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  box_in_t                in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output box_out_t               out_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [ROW_W:0]         cfg_data
);

    logic [ROW_W-1:0]          row_x_reg;
    logic [ROW_W-1:0]          row_y_reg;
    logic [ROW_W-1:0]          row_z_reg;
    logic signed [COORD_W-1:0] offset_x_reg;
    logic signed [COORD_W-1:0] offset_y_reg;
    logic signed [COORD_W-1:0] offset_z_reg;

    logic v1_reg;
    logic v2_reg;
    logic v3_reg;
    logic v4_reg;
    logic v1_next;
    logic v2_next;
    logic v3_next;
    logic v4_next;

    stage_ctrl_t ctrl;

    logic signed [COEFF_W-1:0] coeff_x [3];
    logic signed [COEFF_W-1:0] coeff_y [3];
    logic signed [COEFF_W-1:0] coeff_z [3];
    logic signed [COORD_W-1:0] lo [3];
    logic signed [COORD_W-1:0] hi [3];
    logic signed [COORD_W-1:0] min_x;
    logic signed [COORD_W-1:0] min_y;
    logic signed [COORD_W-1:0] min_z;
    logic signed [COORD_W-1:0] max_x;
    logic signed [COORD_W-1:0] max_y;
    logic signed [COORD_W-1:0] max_z;
    logic                      clip_x;
    logic                      clip_y;
    logic                      clip_z;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_x_reg    <= ROW_X_RESET;
            row_y_reg    <= ROW_Y_RESET;
            row_z_reg    <= ROW_Z_RESET;
            offset_x_reg <= '0;
            offset_y_reg <= '0;
            offset_z_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_ROW_X:    row_x_reg    <= cfg_data[ROW_W-1:0];
                REG_ROW_Y:    row_y_reg    <= cfg_data[ROW_W-1:0];
                REG_ROW_Z:    row_z_reg    <= cfg_data[ROW_W-1:0];
                REG_OFFSET_X: offset_x_reg <= cfg_data[COORD_W-1:0];
                REG_OFFSET_Y: offset_y_reg <= cfg_data[COORD_W-1:0];
                REG_OFFSET_Z: offset_z_reg <= cfg_data[COORD_W-1:0];
                default:      ;
            endcase
        end
    end

    // a stage advances when it is empty or the next one advances
    always_comb
    begin
        ctrl.s4_en = !v4_reg || out_ready;
        ctrl.s3_en = !v3_reg || ctrl.s4_en;
        ctrl.s2_en = !v2_reg || ctrl.s3_en;
        ctrl.s1_en = !v1_reg || ctrl.s2_en;
        v1_next = ctrl.s1_en ? in_valid : v1_reg;
        v2_next = ctrl.s2_en ? v1_reg : v2_reg;
        v3_next = ctrl.s3_en ? v2_reg : v3_reg;
        v4_next = ctrl.s4_en ? v3_reg : v4_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    assign in_ready  = ctrl.s1_en;
    assign out_valid = v4_reg;

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            coeff_x[j] = row_x_reg[j*COEFF_W +: COEFF_W];
            coeff_y[j] = row_y_reg[j*COEFF_W +: COEFF_W];
            coeff_z[j] = row_z_reg[j*COEFF_W +: COEFF_W];
        end
        lo[0] = in_data.in_min_x;
        lo[1] = in_data.in_min_y;
        lo[2] = in_data.in_min_z;
        hi[0] = in_data.in_max_x;
        hi[1] = in_data.in_max_y;
        hi[2] = in_data.in_max_z;
    end

    aat_axis u_axis_x (
        .clk       (clk),
        .ctrl      (ctrl),
        .coeffs    (coeff_x),
        .offset    (offset_x_reg),
        .lo        (lo),
        .hi        (hi),
        .axis_min  (min_x),
        .axis_max  (max_x),
        .axis_clip (clip_x)
    );

    aat_axis u_axis_y (
        .clk       (clk),
        .ctrl      (ctrl),
        .coeffs    (coeff_y),
        .offset    (offset_y_reg),
        .lo        (lo),
        .hi        (hi),
        .axis_min  (min_y),
        .axis_max  (max_y),
        .axis_clip (clip_y)
    );

    aat_axis u_axis_z (
        .clk       (clk),
        .ctrl      (ctrl),
        .coeffs    (coeff_z),
        .offset    (offset_z_reg),
        .lo        (lo),
        .hi        (hi),
        .axis_min  (min_z),
        .axis_max  (max_z),
        .axis_clip (clip_z)
    );

    always_comb
    begin
        out_data.out_min_x = min_x;
        out_data.out_min_y = min_y;
        out_data.out_min_z = min_z;
        out_data.out_max_x = max_x;
        out_data.out_max_y = max_y;
        out_data.out_max_z = max_z;
        out_data.clipped   = clip_x || clip_y || clip_z;
    end

`ifndef SYNTHESIS
    a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> v1_reg)
        else $error("accepted beat did not reach stage one");

    a_s2_holds: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg && !ctrl.s3_en |=> v2_reg)
        else $error("stalled stage two beat dropped");

    a_out_drains: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !v3_reg |=> !out_valid)
        else $error("output beat repeated");

    a_row_x_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready && cfg_index == REG_ROW_X
        |=> row_x_reg == $past(cfg_data[ROW_W-1:0]))
        else $error("row x write lost");
`endif

endmodule
